[src/axis_angle_rotation_matrix_macros.svh]
// Assertion macros shared by the rotation matrix RTL.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// Condition implies consequence in the same cycle.
`define AARM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define AARM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/aarm_pkg.sv]
// Shared types, constants and arithmetic helpers for the rotation matrix block.
package aarm_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ROOT_W            = 32;
   localparam int SQRT_STEPS        = ROOT_W;
   localparam int DIV_STEPS         = 32;
   localparam int Q_W               = 36;
   localparam int M_W               = 34;

   typedef logic signed [Q_W-1:0] q_type;
   typedef logic signed [M_W-1:0] m_type;

   localparam q_type Q30_ONE     = 36'sd1073741824;
   localparam q_type Q30_PI      = 36'sd3373259426;
   localparam q_type Q30_HALF_PI = 36'sd1686629713;
   localparam q_type GAIN_INV    = 36'sd652032874;

   localparam logic signed [15:0] Q14_MAX = 16'sh7FFF;
   localparam logic signed [15:0] Q14_MIN = -16'sh8000;
   localparam logic signed [15:0] Q14_ONE = 16'sd16384;

   // Rotation state handed from one CORDIC cell to the next
   typedef struct packed {
      q_type cx;
      q_type cy;
      q_type z;
      logic  flip;
   } rot_type;

   // Axis data carried alongside the root and divide chains
   typedef struct packed {
      logic [2:0]  neg;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic [15:0] mag_z;
      logic        zero;
   } side_type;

   // atan(2^-i) in Q2.30
   function automatic q_type atan_q30(input int unsigned idx);
      q_type v;
      case (idx)
         0:  v = 36'h03243F6A8;
         1:  v = 36'h01DAC6705;
         2:  v = 36'h00FADBAFC;
         3:  v = 36'h007F56EA6;
         4:  v = 36'h003FEAB76;
         5:  v = 36'h001FFD55B;
         6:  v = 36'h000FFFAAA;
         7:  v = 36'h0007FFF55;
         8:  v = 36'h0003FFFEA;
         9:  v = 36'h0001FFFFD;
         10: v = 36'h0000FFFFF;
         11: v = 36'h00007FFFF;
         12: v = 36'h00003FFFF;
         13: v = 36'h00001FFFF;
         14: v = 36'h00000FFFF;
         15: v = 36'h000007FFF;
         16: v = 36'h000003FFF;
         17: v = 36'h000001FFF;
         18: v = 36'h000000FFF;
         19: v = 36'h0000007FF;
         20: v = 36'h0000003FF;
         21: v = 36'h0000001FF;
         22: v = 36'h0000000FF;
         23: v = 36'h00000007F;
         24: v = 36'h00000003F;
         25: v = 36'h00000001F;
         26: v = 36'h00000000F;
         27: v = 36'h000000008;
         28: v = 36'h000000004;
         29: v = 36'h000000002;
         30: v = 36'h000000001;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q2.30 product, rounded half up
   function automatic q_type mul30(input m_type a, input m_type b);
      logic signed [2*M_W-1:0] p;
      p = a * b;
      p = p + (68'sd1 <<< 29);
      return $signed(p[Q_W+29:30]);
   endfunction

   // Q2.30 to saturated Q1.14
   function automatic logic [15:0] to_q14(input q_type e);
      q_type              w;
      logic signed [19:0] r;
      w = e + 36'sd32768;
      r = $signed(w[35:16]);
      if (r > 20'(Q14_MAX))
         return Q14_MAX;
      else if (r < 20'(Q14_MIN))
         return Q14_MIN;
      else
         return r[15:0];
   endfunction

endpackage

[src/aarm_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per cycle.
module aarm_sqrt_cell #(
   parameter int BIT_POS = 0
) (
   input  logic        clock,
   input  logic [31:0] l2_i,
   input  logic [33:0] rem_i,
   input  logic [31:0] root_i,
   output logic [31:0] l2_o,
   output logic [33:0] rem_o,
   output logic [31:0] root_o
);

   logic [63:0] radicand;
   logic [1:0]  pair;
   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic [35:0] diff;
   logic        fits;
   logic [31:0] l2_ff,   l2_in;
   logic [33:0] rem_ff,  rem_in;
   logic [31:0] root_ff, root_in;

   // bring down the next bit pair and try to subtract
   always_comb begin
      radicand = {l2_i, 32'h0};
      pair     = radicand[2*BIT_POS +: 2];
      rem_sh   = {rem_i, pair};
      trial    = {2'b00, root_i, 2'b01};
      diff     = rem_sh - trial;
      fits     = (rem_sh >= trial);
      rem_in   = fits ? diff[33:0] : rem_sh[33:0];
      root_in  = {root_i[30:0], fits};
      l2_in    = l2_i;
   end

   // advance to the next cell
   always_ff @(posedge clock) begin
      l2_ff   <= l2_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign l2_o   = l2_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

[src/aarm_div_cell.sv]
// One cell of a restoring divide lane: settles one quotient bit per cycle.
module aarm_div_cell (
   input  logic        clock,
   input  logic [31:0] den_i,
   input  logic [31:0] rem_i,
   input  logic [31:0] low_i,
   input  logic [31:0] quo_i,
   output logic [31:0] den_o,
   output logic [31:0] rem_o,
   output logic [31:0] low_o,
   output logic [31:0] quo_o
);

   logic [32:0] rem_sh;
   logic [32:0] diff;
   logic        fits;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] quo_ff, quo_in;

   // shift in the next dividend bit and subtract if it fits
   always_comb begin
      rem_sh = {rem_i, low_i[31]};
      diff   = rem_sh - {1'b0, den_i};
      fits   = (rem_sh >= {1'b0, den_i});
      rem_in = fits ? diff[31:0] : rem_sh[31:0];
      low_in = {low_i[30:0], 1'b0};
      quo_in = {quo_i[30:0], fits};
      den_in = den_i;
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign den_o = den_ff;
   assign rem_o = rem_ff;
   assign low_o = low_ff;
   assign quo_o = quo_ff;

endmodule

[src/aarm_cordic_cell.sv]
// One CORDIC rotation cell: one micro-rotation per cycle.
module aarm_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  aarm_pkg::rot_type rot_i,
   output aarm_pkg::rot_type rot_o
);

   aarm_pkg::q_type   dx;
   aarm_pkg::q_type   dy;
   aarm_pkg::q_type   ang;
   aarm_pkg::rot_type rot_ff, rot_in;

   // rotate toward zero residual angle
   always_comb begin
      dx  = rot_i.cx >>> STAGE;
      dy  = rot_i.cy >>> STAGE;
      ang = aarm_pkg::atan_q30(STAGE);
      rot_in.flip = rot_i.flip;
      if (!rot_i.z[aarm_pkg::Q_W-1]) begin
         rot_in.cx = rot_i.cx - dy;
         rot_in.cy = rot_i.cy + dx;
         rot_in.z  = rot_i.z - ang;
      end else begin
         rot_in.cx = rot_i.cx + dy;
         rot_in.cy = rot_i.cy - dx;
         rot_in.z  = rot_i.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
   end

   assign rot_o = rot_ff;

endmodule

[src/axis_angle_rotation_matrix.sv]
// Top level: pipelined axis-angle to 3x3 rotation matrix generator.
//
// Usage: drive req_angle and req_axis_x/y/z and raise start; an item is
// taken at every rising edge with start high and busy low. busy stays low,
// so one item can be taken every cycle.
// Each result appears on the rsp_ ports for one cycle with rsp_valid high,
// in the order items came in. The chain holds two front stages (squares,
// axis length), 32 square root cells (one root bit each), 32 divide cells
// (one quotient bit each, three lanes side by side) and three product and
// sum stages.
// The CORDIC cells run beside the root chain and their sine and cosine
// wait in a delay line until the quotients arrive.
// A zero-length axis gives the identity and rsp_zero_axis high.
// Reset clears the valid line, so no result leaves the block after reset
// until new items arrive. The receiver cannot stall: every result is
// shown for exactly one cycle.
`include "axis_angle_rotation_matrix_macros.svh"
module axis_angle_rotation_matrix #(
   parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_angle,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22,
   output logic               rsp_zero_axis
);

   localparam int CHAIN  = aarm_pkg::SQRT_STEPS + aarm_pkg::DIV_STEPS;
   localparam int LAT    = CHAIN + 5;
   localparam int CS_DLY = CHAIN - CORDIC_STAGES;
   localparam int SQ_OUT = aarm_pkg::SQRT_STEPS - 1;
   localparam int DV_OUT = CHAIN - 1;

   logic                accept;
   logic [LAT-1:0]      vld_ff;

   // front stages
   logic [31:0]         sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [15:0]  ax_ff, ay_ff, az_ff;
   aarm_pkg::q_type     z_raw, z_fold, z0_ff, z1_ff;
   logic                flip_fold, flip0_ff, flip1_ff;
   logic [31:0]         l2_in, l2_ff;
   aarm_pkg::side_type  side1_in, side1_ff;
   aarm_pkg::side_type  side_ff [0:CHAIN-1];

   // chains
   logic [31:0]         sq_l2   [0:aarm_pkg::SQRT_STEPS];
   logic [33:0]         sq_rem  [0:aarm_pkg::SQRT_STEPS];
   logic [31:0]         sq_root [0:aarm_pkg::SQRT_STEPS];
   logic [31:0]         dv_den  [0:2][0:aarm_pkg::DIV_STEPS];
   logic [31:0]         dv_rem  [0:2][0:aarm_pkg::DIV_STEPS];
   logic [31:0]         dv_low  [0:2][0:aarm_pkg::DIV_STEPS];
   logic [31:0]         dv_quo  [0:2][0:aarm_pkg::DIV_STEPS];
   logic [15:0]         mag     [0:2];
   logic [61:0]         numer   [0:2];
   aarm_pkg::rot_type   rot_w   [0:CORDIC_STAGES];
   aarm_pkg::rot_type   cs_ff   [0:CS_DLY-1];

   // product stages
   aarm_pkg::m_type     n_w [0:2];
   aarm_pkg::q_type     c_w, s_w, omc_w;
   aarm_pkg::q_type     pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   aarm_pkg::q_type     nsx_ff, nsy_ff, nsz_ff, c1_ff, omc1_ff;
   aarm_pkg::q_type     txx_ff, tyy_ff, tzz_ff, txy_ff, txz_ff, tyz_ff;
   aarm_pkg::q_type     nsx2_ff, nsy2_ff, nsz2_ff, c2_ff;
   logic                zero1_ff, zero2_ff;
   aarm_pkg::q_type     e_w [0:8];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // advance the valid line; reset drops all items in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // fold the angle into the CORDIC range
   always_comb begin
      z_raw     = {{3{req_angle[15]}}, req_angle, 17'h0};
      z_fold    = z_raw;
      flip_fold = 1'b0;
      if (z_raw > aarm_pkg::Q30_HALF_PI) begin
         z_fold    = z_raw - aarm_pkg::Q30_PI;
         flip_fold = 1'b1;
      end else if (z_raw < -aarm_pkg::Q30_HALF_PI) begin
         z_fold    = z_raw + aarm_pkg::Q30_PI;
         flip_fold = 1'b1;
      end
   end

   // squares and folded angle
   always_ff @(posedge clock) begin
      sq_x_ff  <= 32'(req_axis_x * req_axis_x);
      sq_y_ff  <= 32'(req_axis_y * req_axis_y);
      sq_z_ff  <= 32'(req_axis_z * req_axis_z);
      ax_ff    <= req_axis_x;
      ay_ff    <= req_axis_y;
      az_ff    <= req_axis_z;
      z0_ff    <= z_fold;
      flip0_ff <= flip_fold;
   end

   // axis length squared, signs and magnitudes
   always_comb begin
      l2_in          = sq_x_ff + sq_y_ff + sq_z_ff;
      side1_in.neg   = {az_ff[15], ay_ff[15], ax_ff[15]};
      side1_in.mag_x = ax_ff[15] ? 16'(-ax_ff) : ax_ff;
      side1_in.mag_y = ay_ff[15] ? 16'(-ay_ff) : ay_ff;
      side1_in.mag_z = az_ff[15] ? 16'(-az_ff) : az_ff;
      side1_in.zero  = (l2_in == '0);
   end

   always_ff @(posedge clock) begin
      l2_ff    <= l2_in;
      side1_ff <= side1_in;
      z1_ff    <= z0_ff;
      flip1_ff <= flip0_ff;
   end

   // carry axis data along the root and divide chains
   always_ff @(posedge clock) begin
      side_ff[0] <= side1_ff;
      for (int j = 1; j < CHAIN; j++) begin
         side_ff[j] <= side_ff[j-1];
      end
   end

   // square root chain, most significant root bit first
   assign sq_l2[0]   = l2_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar j = 0; j < aarm_pkg::SQRT_STEPS; j++) begin : g_sqrt
      aarm_sqrt_cell #(
         .BIT_POS(aarm_pkg::SQRT_STEPS - 1 - j)
      ) u_cell (
         .clock (clock),
         .l2_i  (sq_l2[j]),
         .rem_i (sq_rem[j]),
         .root_i(sq_root[j]),
         .l2_o  (sq_l2[j+1]),
         .rem_o (sq_rem[j+1]),
         .root_o(sq_root[j+1])
      );
   end

   // divide lanes: magnitude * 2^46 / root, rounded half up
   always_comb begin
      mag[0] = side_ff[SQ_OUT].mag_x;
      mag[1] = side_ff[SQ_OUT].mag_y;
      mag[2] = side_ff[SQ_OUT].mag_z;
      for (int k = 0; k < 3; k++) begin
         numer[k] = {mag[k], 46'h0} +
                    62'(sq_root[aarm_pkg::SQRT_STEPS][31:1]);
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      assign dv_den[k][0] = sq_root[aarm_pkg::SQRT_STEPS];
      assign dv_rem[k][0] = {2'b00, numer[k][61:32]};
      assign dv_low[k][0] = numer[k][31:0];
      assign dv_quo[k][0] = '0;
      for (genvar j = 0; j < aarm_pkg::DIV_STEPS; j++) begin : g_div
         aarm_div_cell u_cell (
            .clock(clock),
            .den_i(dv_den[k][j]),
            .rem_i(dv_rem[k][j]),
            .low_i(dv_low[k][j]),
            .quo_i(dv_quo[k][j]),
            .den_o(dv_den[k][j+1]),
            .rem_o(dv_rem[k][j+1]),
            .low_o(dv_low[k][j+1]),
            .quo_o(dv_quo[k][j+1])
         );
      end
   end

   // CORDIC chain beside the root chain
   always_comb begin
      rot_w[0].cx   = aarm_pkg::GAIN_INV;
      rot_w[0].cy   = '0;
      rot_w[0].z    = z1_ff;
      rot_w[0].flip = flip1_ff;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      aarm_cordic_cell #(
         .STAGE(i)
      ) u_cell (
         .clock(clock),
         .rot_i(rot_w[i]),
         .rot_o(rot_w[i+1])
      );
   end

   // hold sine and cosine until the quotients arrive
   always_ff @(posedge clock) begin
      cs_ff[0] <= rot_w[CORDIC_STAGES];
      for (int j = 1; j < CS_DLY; j++) begin
         cs_ff[j] <= cs_ff[j-1];
      end
   end

   // signed unit axis, cosine and sine
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         n_w[k] = side_ff[DV_OUT].neg[k] ?
                  -$signed({2'b00, dv_quo[k][aarm_pkg::DIV_STEPS]}) :
                   $signed({2'b00, dv_quo[k][aarm_pkg::DIV_STEPS]});
      end
      c_w   = cs_ff[CS_DLY-1].flip ? -cs_ff[CS_DLY-1].cx : cs_ff[CS_DLY-1].cx;
      s_w   = cs_ff[CS_DLY-1].flip ? -cs_ff[CS_DLY-1].cy : cs_ff[CS_DLY-1].cy;
      omc_w = aarm_pkg::Q30_ONE - c_w;
   end

   // axis products and sine terms
   always_ff @(posedge clock) begin
      pxx_ff   <= aarm_pkg::mul30(n_w[0], n_w[0]);
      pyy_ff   <= aarm_pkg::mul30(n_w[1], n_w[1]);
      pzz_ff   <= aarm_pkg::mul30(n_w[2], n_w[2]);
      pxy_ff   <= aarm_pkg::mul30(n_w[0], n_w[1]);
      pxz_ff   <= aarm_pkg::mul30(n_w[0], n_w[2]);
      pyz_ff   <= aarm_pkg::mul30(n_w[1], n_w[2]);
      nsx_ff   <= aarm_pkg::mul30(n_w[0], s_w[aarm_pkg::M_W-1:0]);
      nsy_ff   <= aarm_pkg::mul30(n_w[1], s_w[aarm_pkg::M_W-1:0]);
      nsz_ff   <= aarm_pkg::mul30(n_w[2], s_w[aarm_pkg::M_W-1:0]);
      c1_ff    <= c_w;
      omc1_ff  <= omc_w;
      zero1_ff <= side_ff[DV_OUT].zero;
   end

   // scale by one minus cosine
   always_ff @(posedge clock) begin
      txx_ff   <= aarm_pkg::mul30(pxx_ff[aarm_pkg::M_W-1:0], omc1_ff[aarm_pkg::M_W-1:0]);
      tyy_ff   <= aarm_pkg::mul30(pyy_ff[aarm_pkg::M_W-1:0], omc1_ff[aarm_pkg::M_W-1:0]);
      tzz_ff   <= aarm_pkg::mul30(pzz_ff[aarm_pkg::M_W-1:0], omc1_ff[aarm_pkg::M_W-1:0]);
      txy_ff   <= aarm_pkg::mul30(pxy_ff[aarm_pkg::M_W-1:0], omc1_ff[aarm_pkg::M_W-1:0]);
      txz_ff   <= aarm_pkg::mul30(pxz_ff[aarm_pkg::M_W-1:0], omc1_ff[aarm_pkg::M_W-1:0]);
      tyz_ff   <= aarm_pkg::mul30(pyz_ff[aarm_pkg::M_W-1:0], omc1_ff[aarm_pkg::M_W-1:0]);
      nsx2_ff  <= nsx_ff;
      nsy2_ff  <= nsy_ff;
      nsz2_ff  <= nsz_ff;
      c2_ff    <= c1_ff;
      zero2_ff <= zero1_ff;
   end

   // matrix entries
   always_comb begin
      e_w[0] = txx_ff + c2_ff;
      e_w[1] = txy_ff - nsz2_ff;
      e_w[2] = txz_ff + nsy2_ff;
      e_w[3] = txy_ff + nsz2_ff;
      e_w[4] = tyy_ff + c2_ff;
      e_w[5] = tyz_ff - nsx2_ff;
      e_w[6] = txz_ff - nsy2_ff;
      e_w[7] = tyz_ff + nsx2_ff;
      e_w[8] = tzz_ff + c2_ff;
   end

   // round, saturate and register the item; identity for a zero axis
   always_ff @(posedge clock) begin
      if (zero2_ff) begin
         rsp_m00 <= aarm_pkg::Q14_ONE;
         rsp_m01 <= '0;
         rsp_m02 <= '0;
         rsp_m10 <= '0;
         rsp_m11 <= aarm_pkg::Q14_ONE;
         rsp_m12 <= '0;
         rsp_m20 <= '0;
         rsp_m21 <= '0;
         rsp_m22 <= aarm_pkg::Q14_ONE;
      end else begin
         rsp_m00 <= aarm_pkg::to_q14(e_w[0]);
         rsp_m01 <= aarm_pkg::to_q14(e_w[1]);
         rsp_m02 <= aarm_pkg::to_q14(e_w[2]);
         rsp_m10 <= aarm_pkg::to_q14(e_w[3]);
         rsp_m11 <= aarm_pkg::to_q14(e_w[4]);
         rsp_m12 <= aarm_pkg::to_q14(e_w[5]);
         rsp_m20 <= aarm_pkg::to_q14(e_w[6]);
         rsp_m21 <= aarm_pkg::to_q14(e_w[7]);
         rsp_m22 <= aarm_pkg::to_q14(e_w[8]);
      end
      rsp_zero_axis <= zero2_ff;
   end

   assign rsp_valid = vld_ff[LAT-1];

   `AARM_ASSERT_IMPLY(a_root_floor, clock, reset,
      vld_ff[SQ_OUT+2] && !side_ff[SQ_OUT].zero,
      sq_root[aarm_pkg::SQRT_STEPS] >= 32'h0001_0000,
      "root below floor for a nonzero axis")

   `AARM_ASSERT_IMPLY(a_quo_bound, clock, reset,
      vld_ff[DV_OUT+2] && !side_ff[DV_OUT].zero,
      dv_quo[0][aarm_pkg::DIV_STEPS] <= 32'h4000_0000,
      "normalized component above one")

   `AARM_ASSERT_NEXT(a_square_sign, clock, reset,
      vld_ff[DV_OUT+2],
      !pxx_ff[aarm_pkg::Q_W-1] && !pyy_ff[aarm_pkg::Q_W-1],
      "negative square of a component")

   `AARM_ASSERT_IMPLY(a_identity, clock, reset,
      rsp_valid && rsp_zero_axis,
      rsp_m00 == aarm_pkg::Q14_ONE && rsp_m11 == aarm_pkg::Q14_ONE &&
      rsp_m22 == aarm_pkg::Q14_ONE && rsp_m01 == '0 && rsp_m12 == '0,
      "zero axis without identity")

   `AARM_ASSERT_IMPLY(a_diag_range, clock, reset,
      rsp_valid,
      rsp_m00 <= 16'sd16896 && rsp_m00 >= -16'sd16896 &&
      rsp_m11 <= 16'sd16896 && rsp_m11 >= -16'sd16896,
      "diagonal entry out of rotation range")

endmodule

[bench/rotation_checker.sv]
// Checker for the rotation matrix block: predicts each matrix and compares results.
module rotation_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_angle,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_m00,
   input  logic signed [15:0] rsp_m01,
   input  logic signed [15:0] rsp_m02,
   input  logic signed [15:0] rsp_m10,
   input  logic signed [15:0] rsp_m11,
   input  logic signed [15:0] rsp_m12,
   input  logic signed [15:0] rsp_m20,
   input  logic signed [15:0] rsp_m21,
   input  logic signed [15:0] rsp_m22,
   input  logic               rsp_zero_axis,
   output int                 fail_count,
   output int                 pending
);

   localparam int      NUM_STAGES = aarm_pkg::CORDIC_STAGES_DEF;
   localparam longint  ONE_Q30    = 64'sd1073741824;
   localparam longint  PI_Q30     = 64'sd3373259426;
   localparam longint  HPI_Q30    = 64'sd1686629713;
   localparam longint  KINV_Q30   = 64'sd652032874;

   typedef struct {
      logic signed [15:0] m [9];
      logic               zero_axis;
   } matrix_type;

   matrix_type matrix_q[$];

   const longint arctan_tab [32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000};

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic signed [15:0] sat_q14(longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned rt, bt;
      rt = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= rt + bt) begin
            v  = v - (rt + bt);
            rt = (rt >> 1) + bt;
         end else begin
            rt = rt >> 1;
         end
         bt = bt >> 2;
      end
      return rt;
   endfunction

   function automatic longint unit_comp(longint comp, longint unsigned len);
      longint unsigned mag, q;
      mag = longint'(comp < 0 ? -comp : comp) << 46;
      q   = (mag + (len >> 1)) / len;
      return comp < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic matrix_type predict_matrix(logic signed [15:0] ang,
         logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
      matrix_type      res;
      longint          ax, ay, az, ph, cx, cy, dx, dy, c, s, omc, nx, ny, nz;
      longint          e [9];
      longint unsigned l2, len;
      logic            flip;
      ax = x; ay = y; az = z;
      l2 = ax * ax + ay * ay + az * az;
      if (l2 == 0) begin
         foreach (res.m[k]) res.m[k] = (k % 4 == 0) ? aarm_pkg::Q14_ONE : 16'sd0;
         res.zero_axis = 1'b1;
         return res;
      end
      // fold the angle into the CORDIC range
      ph   = longint'(ang) * 131072;
      flip = 1'b0;
      if (ph > HPI_Q30) begin
         ph = ph - PI_Q30; flip = 1'b1;
      end else if (ph < -HPI_Q30) begin
         ph = ph + PI_Q30; flip = 1'b1;
      end
      cx = KINV_Q30;
      cy = 0;
      for (int i = 0; i < NUM_STAGES && i < 32; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (ph >= 0) begin
            cx = cx - dx; cy = cy + dy; ph = ph - arctan_tab[i];
         end else begin
            cx = cx + dx; cy = cy - dy; ph = ph + arctan_tab[i];
         end
      end
      c   = flip ? -cx : cx;
      s   = flip ? -cy : cy;
      omc = ONE_Q30 - c;
      len = root64(l2 << 32);
      nx  = unit_comp(ax, len);
      ny  = unit_comp(ay, len);
      nz  = unit_comp(az, len);
      e[0] = qmul(qmul(nx, nx), omc) + c;
      e[1] = qmul(qmul(nx, ny), omc) - qmul(nz, s);
      e[2] = qmul(qmul(nx, nz), omc) + qmul(ny, s);
      e[3] = qmul(qmul(ny, nx), omc) + qmul(nz, s);
      e[4] = qmul(qmul(ny, ny), omc) + c;
      e[5] = qmul(qmul(ny, nz), omc) - qmul(nx, s);
      e[6] = qmul(qmul(nz, nx), omc) - qmul(ny, s);
      e[7] = qmul(qmul(nz, ny), omc) + qmul(nx, s);
      e[8] = qmul(qmul(nz, nz), omc) + c;
      foreach (res.m[k]) res.m[k] = sat_q14(e[k]);
      res.zero_axis = 1'b0;
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // predict on each accepted item, compare each result with the oldest prediction
   always @(posedge clock) begin
      matrix_type         want;
      logic signed [15:0] got [9];
      logic               bad;
      if (!reset) begin
         if (start && !busy)
            matrix_q.push_back(predict_matrix(req_angle, req_axis_x, req_axis_y, req_axis_z));
         if (rsp_valid) begin
            got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                    rsp_m20, rsp_m21, rsp_m22};
            if (matrix_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result m00=%0d", rsp_m00);
            end else begin
               want = matrix_q.pop_front();
               bad  = (want.zero_axis !== rsp_zero_axis);
               foreach (got[k]) if (got[k] !== want.m[k]) bad = 1'b1;
               if (bad) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p zero=%0b, got %p zero=%0b",
                              want.m, want.zero_axis, got, rsp_zero_axis);
               end
            end
         end
      end
      pending = matrix_q.size();
   end

endmodule

[bench/tb.sv]
// Testbench top: drives rotation requests into the block and gives the verdict.
module tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_angle = '0, req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic               rsp_valid, rsp_zero_axis;
   logic signed [15:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [15:0] rsp_m20, rsp_m21, rsp_m22;
   int                 fail_count, pending;
   int                 cycle_count = 0;
   int                 idle_pct = 0;

   axis_angle_rotation_matrix i_dut (.*);
   rotation_checker i_checker (.*);

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 200000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // present one item, hold until taken, maybe idle after
   task automatic send_rotation(logic signed [15:0] ang, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [15:0] z);
      @(negedge clock);
      start      <= 1'b1;
      req_angle  <= ang;
      req_axis_x <= x;
      req_axis_y <= y;
      req_axis_z <= z;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start     <= 1'b0;
         req_angle <= 16'($urandom);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // random item: mostly small or mixed axes, a few zero axes
   task automatic send_random();
      int sel;
      logic signed [15:0] x, y, z;
      sel = $urandom_range(19);
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      if (sel == 0) begin
         x = 0; y = 0; z = 0;
      end else if (sel < 6) begin
         x = $signed(16'($urandom_range(8))) - 16'sd4;
         y = $signed(16'($urandom_range(8))) - 16'sd4;
         z = $signed(16'($urandom_range(8))) - 16'sd4;
      end else if (sel < 8) begin
         x = 0;
      end
      send_rotation(16'($urandom), x, y, z);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero axis, extreme fields, quarter-turn folds
      send_rotation(16'sd1000, 0, 0, 0);
      send_rotation(-16'sd32768, 0, 0, 0);
      send_rotation(16'sd0, 16'sd1, 0, 0);
      send_rotation(16'sd32767, 0, 16'sd1, 0);
      send_rotation(-16'sd32768, 0, 0, 16'sd1);
      send_rotation(16'sd12868, 16'sd1, 16'sd1, 16'sd1);
      send_rotation(16'sd12869, 16'sd1, 16'sd1, 16'sd1);
      send_rotation(-16'sd12868, -16'sd1, 16'sd2, -16'sd3);
      send_rotation(-16'sd12869, -16'sd1, 16'sd2, -16'sd3);
      send_rotation(16'sd25736, 16'sd32767, 0, 0);
      send_rotation(-16'sd25736, -16'sd32768, -16'sd32768, -16'sd32768);
      send_rotation(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_rotation(16'sd6434, -16'sd32768, 16'sd32767, 0);
      send_rotation(-16'sd1, 0, -16'sd32768, 16'sd1);
      send_rotation(16'sd8192, 16'sd3, 16'sd4, 0);
      drain();

      // no idling
      idle_pct = 0;
      repeat (300) send_random();
      drain();
      // sender idle three quarters of the time
      idle_pct = 75;
      repeat (300) send_random();
      drain();
      idle_pct = 35;
      repeat (300) send_random();
      drain();

      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/aarm_pkg.sv
src/aarm_sqrt_cell.sv
src/aarm_div_cell.sv
src/aarm_cordic_cell.sv
src/axis_angle_rotation_matrix.sv
bench/rotation_checker.sv
bench/tb.sv
